// File: rtl/core/bdel_pkg.sv
`default_nettype none
package bdel_pkg;

  localparam int unsigned DEFAULT_CAPACITY   = 16;
  localparam int unsigned DEFAULT_DATA_WIDTH = 32;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FIND       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_ERASE      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_TAIL,
    CELL_SHIFT_UP,
    CELL_CLOSE,
    CELL_MATCH,
    CELL_SCAN
  } cell_op_e;

endpackage
`default_nettype wire

// File: rtl/core/bounded_double_ended_list.sv
// Push, pop and erase: after acceptance the result is registered once the output is free.
// Find: cells register their compare, then match flags shift toward the front one cell per
// cycle until a hit or the count is reached.
// One request in flight; a new request is taken once the previous result is registered.
// rst_ni (async, active low) empties the list; cell contents stay undefined until written.
`default_nettype none
module bounded_double_ended_list
  import bdel_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEFAULT_CAPACITY,
  parameter int unsigned DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  input  wire logic [POS_W-1:0]    position_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [FOUND_W-1:0]  found_position_o,
  output logic      [VALUE_W-1:0]  front_value_o,
  output logic      [VALUE_W-1:0]  back_value_o,
  output logic      [COUNT_W-1:0]  entry_count_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [FOUND_W-1:0]  found_q, found_d;
  logic                out_valid_q, out_valid_d;

  logic [STATUS_W-1:0] out_status_q;
  logic [FOUND_W-1:0]  out_found_q;
  logic [VALUE_W-1:0]  out_front_q, out_back_q;
  logic [COUNT_W-1:0]  out_count_q;

  cell_op_e              cell_op;
  logic [CNT_W-1:0]      cell_pos;
  logic [DATA_WIDTH-1:0] val_ext;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  logic [DATA_WIDTH-1:0] back_data;
  logic [CNT_W-1:0]      tail_idx;
  logic                  accept;
  logic                  out_free;
  logic                  is_full, is_empty;
  logic                  pos_bad;

  assign val_ext  = DATA_WIDTH'(value_i);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_full  = (count_q >= CapCount);
  assign is_empty = (count_q == '0);
  assign pos_bad  = (CMP_W'(position_i) >= CMP_W'(count_q));
  assign tail_idx = count_q - CNT_W'(1);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic [DATA_WIDTH-1:0] next_data;
    logic                  next_match;

    if (g == 0) begin : g_first
      assign prev_data = val_ext;
    end else begin : g_mid
      assign prev_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_data  = '0;
      assign next_match = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[g+1];
      assign next_match = cell_match[g+1];
    end

    bdel_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CNT_W),
      .INDEX     (g)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .val_i       (val_ext),
      .count_i     (count_q),
      .pos_i       (cell_pos),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .next_match_i(next_match),
      .data_o      (cell_data[g]),
      .match_o     (cell_match[g])
    );
  end

  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_idx == CNT_W'(i)) back_data = back_data | cell_data[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    cell_op     = CELL_HOLD;
    cell_pos    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          found_d  = '0;
          state_d  = S_RESP;
          unique case (action_i)
            ACT_PUSH_BACK: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                cell_op = CELL_LOAD_TAIL;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_PUSH_FRONT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                cell_op = CELL_SHIFT_UP;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_POP_BACK: begin
              if (is_empty) status_d = ST_EMPTY;
              else count_d = count_q - CNT_W'(1);
            end
            ACT_POP_FRONT: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                cell_op = CELL_CLOSE;
                count_d = count_q - CNT_W'(1);
              end
            end
            ACT_FIND: begin
              cell_op  = CELL_MATCH;
              status_d = ST_MISS;
              scan_d   = '0;
              state_d  = S_SCAN;
            end
            ACT_ERASE: begin
              if (pos_bad) begin
                status_d = ST_MISS;
              end else begin
                cell_op  = CELL_CLOSE;
                cell_pos = CNT_W'(position_i);
                count_d  = count_q - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        priority if (scan_q == count_q) begin
          state_d = S_RESP;
        end else if (cell_match[0]) begin
          status_d = ST_OK;
          found_d  = FOUND_W'(scan_q);
          state_d  = S_RESP;
        end else begin
          cell_op = CELL_SCAN;
          scan_d  = scan_q + CNT_W'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      status_q    <= ST_OK;
      found_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      status_q    <= status_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && out_free) begin
      out_status_q <= status_q;
      out_found_q  <= found_q;
      out_front_q  <= is_empty ? '0 : VALUE_W'(cell_data[0]);
      out_back_q   <= VALUE_W'(back_data);
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign front_value_o    = out_front_q;
  assign back_value_o     = out_back_q;
  assign entry_count_o    = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("entry count above capacity");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_full && (action_i == ACT_PUSH_BACK || action_i == ACT_PUSH_FRONT)
    |=> count_q == CapCount && status_q == ST_FULL)
    else $error("push on full list changed the count");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> scan_q <= count_q)
    else $error("find scan ran past the count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted request produced no pending result");

endmodule
`default_nettype wire

// File: rtl/core/bdel_cell.sv
`default_nettype none
module bdel_cell
  import bdel_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DEFAULT_DATA_WIDTH,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_op_e              op_i,
  input  wire logic [DATA_WIDTH-1:0] val_i,
  input  wire logic [CNT_W-1:0]      count_i,
  input  wire logic [CNT_W-1:0]      pos_i,
  input  wire logic [DATA_WIDTH-1:0] prev_data_i,
  input  wire logic [DATA_WIDTH-1:0] next_data_i,
  input  wire logic                  next_match_i,
  output logic      [DATA_WIDTH-1:0] data_o,
  output logic                       match_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q;
  logic                  match_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      CELL_LOAD_TAIL: begin
        if (count_i == MyIdx) data_q <= val_i;
      end
      CELL_SHIFT_UP: data_q <= prev_data_i;
      CELL_CLOSE: begin
        if (MyIdx >= pos_i) data_q <= next_data_i;
      end
      CELL_MATCH: match_q <= (data_q == val_i);
      CELL_SCAN:  match_q <= next_match_i;
      default: ;
    endcase
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

// File: tb/tb_bounded_double_ended_list.sv
`timescale 1ns / 1ps
module tb_bounded_double_ended_list;
  import bdel_pkg::*;

  localparam int unsigned LIST_DEPTH = DEFAULT_CAPACITY;
  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 1050;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
  } list_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found;
    logic [VALUE_W-1:0]  front;
    logic [VALUE_W-1:0]  back;
    logic [COUNT_W-1:0]  count;
  } list_res_t;

  typedef struct {
    list_req_t req;
    int        reps;
    bit        typed;
    list_res_t res;
  } list_row_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  typedef enum int {MIX_DRAIN, MIX_BALANCED, MIX_FILL} mix_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ACTION_W-1:0] action_i;
  logic [VALUE_W-1:0]  value_i;
  logic [POS_W-1:0]    position_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [FOUND_W-1:0]  found_position_o;
  logic [VALUE_W-1:0]  front_value_o;
  logic [VALUE_W-1:0]  back_value_o;
  logic [COUNT_W-1:0]  entry_count_o;

  bounded_double_ended_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .front_value_o   (front_value_o),
    .back_value_o    (back_value_o),
    .entry_count_o   (entry_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [VALUE_W-1:0] list_cells [LIST_DEPTH];
  int                 list_len = 0;
  list_res_t          pending_results [$];
  list_row_t          directed_rows [$];
  int                 fail_count = 0;
  int                 accepted_count = 0;
  int                 burst_left = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;

  logic [VALUE_W-1:0] value_pool [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
    32'h1234_5678, 32'hDEAD_BEEF, 32'h0000_00FF, 32'h7FFF_FFFF
  };

  // next state of the list and the result it reports
  task automatic apply_list_op(input list_req_t r, output list_res_t res);
    int  i;
    bit  hit;
    res = '{status: ST_OK, found: '0, front: '0, back: '0, count: '0};
    hit = 1'b0;
    case (r.action)
      ACT_PUSH_BACK: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_cells[list_len] = r.value;
          list_len++;
        end
      end
      ACT_PUSH_FRONT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > 0; i--) list_cells[i] = list_cells[i-1];
          list_cells[0] = r.value;
          list_len++;
        end
      end
      ACT_POP_BACK: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_len--;
      end
      ACT_POP_FRONT: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      ACT_FIND: begin
        res.status = ST_MISS;
        for (i = 0; i < list_len; i++) begin
          if (!hit && list_cells[i] == r.value) begin
            hit = 1'b1;
            res.status = ST_OK;
            res.found = FOUND_W'(i);
          end
        end
      end
      ACT_ERASE: begin
        if (int'(r.position) >= list_len) begin
          res.status = ST_MISS;
        end else begin
          for (i = int'(r.position); i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      default: begin
      end
    endcase
    if (list_len > 0) begin
      res.front = list_cells[0];
      res.back  = list_cells[list_len-1];
    end
    res.count = COUNT_W'(list_len);
  endtask

  function automatic list_row_t make_row(input logic [ACTION_W-1:0] action,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [POS_W-1:0] position, input int reps,
                                         input bit typed, input logic [STATUS_W-1:0] status,
                                         input logic [FOUND_W-1:0] found,
                                         input logic [VALUE_W-1:0] front,
                                         input logic [VALUE_W-1:0] back,
                                         input logic [COUNT_W-1:0] count);
    list_row_t row;
    row.req   = '{action: action, value: value, position: position};
    row.reps  = reps;
    row.typed = typed;
    row.res   = '{status: status, found: found, front: front, back: back, count: count};
    return row;
  endfunction

  task automatic add_row(input list_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return value_pool[$urandom_range(7)];
    if (sel == 4) return $urandom_range(1) ? '1 : '0;
    return $urandom();
  endfunction

  task automatic make_random_request(input mix_e mix, output list_req_t r);
    int unsigned roll;
    int          push_w;
    int          pop_w;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin push_w = 55; pop_w = 12; end
      MIX_DRAIN: begin push_w = 12; pop_w = 55; end
      default:   begin push_w = 33; pop_w = 30; end
    endcase
    r.value    = pick_value();
    r.position = POS_W'($urandom_range(15));
    if (roll < 2) begin
      r.action = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
    end else if (roll < 2 + push_w) begin
      r.action = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    end else if (roll < 2 + push_w + pop_w) begin
      r.action = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    end else if (roll < 17 + push_w + pop_w) begin
      r.action = ACT_FIND;
      if (list_len > 0 && $urandom_range(9) < 6)
        r.value = list_cells[$urandom_range(list_len - 1)];
    end else begin
      r.action = ACT_ERASE;
      if ($urandom_range(9) < 7) r.position = POS_W'($urandom_range(list_len));
    end
  endtask

  task automatic send_request(input list_req_t r, input bit typed, input list_res_t typed_res);
    list_res_t res;
    int        gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (hold_left > 0 || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i   <= r.action;
    value_i    <= r.value;
    position_i <= r.position;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_list_op(r, res);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    accepted_count++;
  endtask

  initial begin
    list_req_t req;
    list_res_t unused_res;
    mix_e      mix;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = ACT_PUSH_BACK;
    value_i    = '0;
    position_i = '0;
    mix        = MIX_FILL;
    unused_res = '{status: ST_OK, found: '0, front: '0, back: '0, count: '0};

    add_row(make_row(ACT_POP_BACK, '0, '0, 1, 1, ST_EMPTY, 0, 0, 0, 0));
    add_row(make_row(ACT_POP_FRONT, '0, '0, 1, 1, ST_EMPTY, 0, 0, 0, 0));
    add_row(make_row(ACT_FIND, '0, '0, 1, 1, ST_MISS, 0, 0, 0, 0));
    add_row(make_row(ACT_ERASE, '0, 4'd0, 1, 1, ST_MISS, 0, 0, 0, 0));
    add_row(make_row(ACT_ERASE, '1, 4'd15, 1, 1, ST_MISS, 0, 0, 0, 0));
    add_row(make_row(ACT_SPARE_6, '1, 4'd15, 1, 1, ST_OK, 0, 0, 0, 0));
    add_row(make_row(ACT_PUSH_BACK, 32'hFFFF_FFFF, '0, 1, 1,
                     ST_OK, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    add_row(make_row(ACT_PUSH_FRONT, 32'h0, '0, 1, 1,
                     ST_OK, 0, 32'h0, 32'hFFFF_FFFF, 2));
    add_row(make_row(ACT_FIND, 32'hFFFF_FFFF, '0, 1, 1,
                     ST_OK, 1, 32'h0, 32'hFFFF_FFFF, 2));
    add_row(make_row(ACT_SPARE_7, 32'h1234_5678, 4'd15, 1, 1,
                     ST_OK, 0, 32'h0, 32'hFFFF_FFFF, 2));
    add_row(make_row(ACT_ERASE, '0, 4'd2, 1, 1,
                     ST_MISS, 0, 32'h0, 32'hFFFF_FFFF, 2));
    add_row(make_row(ACT_ERASE, '0, 4'd0, 1, 1,
                     ST_OK, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    add_row(make_row(ACT_PUSH_BACK, 32'hA5A5_A5A5, '0, 14, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_PUSH_FRONT, 32'h5A5A_5A5A, '0, 1, 0, 0, 0, 0, 0, 0));
    // full list refuses both pushes
    add_row(make_row(ACT_PUSH_BACK, '0, '0, 1, 1,
                     ST_FULL, 0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 16));
    add_row(make_row(ACT_PUSH_FRONT, '1, '1, 1, 1,
                     ST_FULL, 0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 16));
    add_row(make_row(ACT_FIND, 32'hA5A5_A5A5, '0, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_FIND, 32'h1357_9BDF, '0, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_ERASE, '0, 4'd15, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_ERASE, '0, 4'd7, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_ERASE, '0, 4'd15, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_POP_BACK, '0, '0, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_POP_FRONT, '0, '0, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_PUSH_FRONT, 32'h8000_0000, '0, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_row(ACT_FIND, 32'h8000_0000, '0, 1, 0, 0, 0, 0, 0, 0));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) begin
      for (int n = 0; n < directed_rows[k].reps; n++)
        send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) mix = mix_e'($urandom_range(2));
      make_random_request(mix, req);
      send_request(req, 1'b0, unused_res);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int       rx_cycle;
    rx_mode_e rx_mode;
    bit       stall_next;
    rx_cycle    = 0;
    rx_mode     = RX_FREE;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle % 150 == 0) rx_mode = rx_mode_e'($urandom_range(3));
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
        // long hold-off: the block holds its pending result and stalls its input
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES;
        stall_next = 1'b1;
      end else begin
        case (rx_mode)
          RX_RANDOM:   stall_next = ($urandom_range(2) == 0);
          RX_PERIODIC: stall_next = ((rx_cycle % 5) < 2);
          RX_HEAVY:    stall_next = ($urandom_range(3) != 0);
          default:     stall_next = 1'b0;
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  always @(posedge clk_i) begin
    list_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending request");
        fail_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (found_position_o !== want.found) begin
          $error("found_position: expected %0d, got %0d", want.found, found_position_o);
          fail_count++;
        end
        if (front_value_o !== want.front) begin
          $error("front_value: expected %h, got %h", want.front, front_value_o);
          fail_count++;
        end
        if (back_value_o !== want.back) begin
          $error("back_value: expected %h, got %h", want.back, back_value_o);
          fail_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
